// ----- rtl/snnu_pkg.sv -----
// ---------------------------------------------------------------------------
// snnu_pkg: shared types and constants for the sparse network update engine
// Opcodes, status codes, sequencer states and the sigmoid lookup table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package snnu_pkg;

   localparam int SIG_SIZE = 1024;

   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_LINK     = 2'd0;
   localparam opcode_type OP_SET      = 2'd1;
   localparam opcode_type OP_READ     = 2'd2;
   localparam opcode_type OP_ACTIVATE = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type STAT_OK        = 2'd0;
   localparam status_type STAT_NODE_FULL = 2'd1;
   localparam status_type STAT_LINK_FULL = 2'd2;
   localparam status_type STAT_UNKNOWN   = 2'd3;

   typedef enum logic [15:0] {
      S_IDLE   = 16'h0001,
      S_NSCAN  = 16'h0002,
      S_LSCAN  = 16'h0004,
      S_DECIDE = 16'h0008,
      S_ADDF   = 16'h0010,
      S_ADDT   = 16'h0020,
      S_SRD    = 16'h0040,
      S_CLR    = 16'h0080,
      S_LRD    = 16'h0100,
      S_SRC    = 16'h0200,
      S_MUL    = 16'h0400,
      S_ACC    = 16'h0800,
      S_NRD    = 16'h1000,
      S_CVT    = 16'h2000,
      S_NWR    = 16'h4000,
      S_DONE   = 16'h8000
   } state_type;

   typedef logic [SIG_SIZE-1:0][15:0] sig_table_type;

   localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] al, ah, bl, bh, p0, p1, p2, p3, mid, lo, hi;
      al  = {32'd0, a[31:0]};
      ah  = {32'd0, a[63:32]};
      bl  = {32'd0, b[31:0]};
      bh  = {32'd0, b[63:32]};
      p0  = al * bl;
      p1  = al * bh;
      p2  = ah * bl;
      p3  = ah * bh;
      mid = {32'd0, p0[63:32]} + {32'd0, p1[31:0]} + {32'd0, p2[31:0]};
      lo  = {mid[31:0], p0[31:0]};
      hi  = p3 + {32'd0, p1[63:32]} + {32'd0, p2[63:32]} + {32'd0, mid[63:32]};
      return {hi[61:0], lo[63:62]};
   endfunction

   function automatic logic [15:0] rounded_ratio(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] r;
      r = udiv64(num << 13, den) + 64'd1;
      return r[16:1];
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type t;
      logic [63:0]   term, step, q, den;
      t    = '0;
      term = ONE_Q62;
      step = ONE_Q62;
      q    = ONE_Q62;
      for (int n = 1; n < 16; n++) begin
         term = udiv64(term >> 6, 64'(n));
         if (n % 2 == 1) begin
            step = step - term;
         end else begin
            step = step + term;
         end
      end
      for (int m = 0; m <= 512; m++) begin
         den = (ONE_Q62 + q) >> 20;
         if (m <= 511) begin
            t[512 + m] = rounded_ratio(ONE_Q62 >> 20, den);
         end
         if (m >= 1) begin
            t[512 - m] = rounded_ratio(q >> 20, den);
         end
         q = mul_q62(q, step);
      end
      return t;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

`default_nettype wire

// ----- rtl/snnu_ram.sv -----
// ---------------------------------------------------------------------------
// snnu_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module snnu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/sparse_neural_net_update.sv -----
// ---------------------------------------------------------------------------
// sparse_neural_net_update: sparse recurrent sigmoid network engine
// Node and link tables in RAM, one shared multiply-accumulate path.
// ---------------------------------------------------------------------------
//  channel | direction | contents
//  req     | in        | tuser: opcode; tdata: node_id, to_node_id, value
//  rsp     | out       | tuser: status; tdata: read_value
//
//  One transaction at a time; req_tready is high only while idle.
//  Set and read scan the node table; link scans the nodes, then the links if both ends exist.
//  Activate clears the sums, runs each link through the single RAM-fed MAC path, then maps each node via the table.
//  Reset clears the table counts and the handshake; no clearing pass.
//  A pending response stalls the sequencer only at completion.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sparse_neural_net_update #(
   parameter int NODES = 64,
   parameter int LINKS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // [1:0] opcode
   input  wire logic [47:0] req_tdata,   // [15:0] node_id, [31:16] to_node_id, [47:32] value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [1:0]       rsp_tuser,   // [1:0] status
   output logic [15:0]      rsp_tdata    // [15:0] read_value
);

   localparam int NODE_AW = $clog2(NODES);
   localparam int LINK_AW = (LINKS > 1) ? $clog2(LINKS) : 1;
   localparam int NCNT_W  = $clog2(NODES + 1);
   localparam int LCNT_W  = $clog2(LINKS + 1);
   localparam int IDX_W   = (NCNT_W > LCNT_W) ? NCNT_W : LCNT_W;
   localparam logic [NCNT_W:0]   NODES_LIM = NODES[NCNT_W:0];
   localparam logic [LCNT_W-1:0] LINKS_LIM = LINKS[LCNT_W-1:0];

   snnu_pkg::state_type  state_ff, state_in;
   snnu_pkg::opcode_type op_ff, op_in;
   logic [15:0]          id_a_ff, id_a_in, id_b_ff, id_b_in;
   logic signed [15:0]   value_ff, value_in;
   logic [NCNT_W-1:0]    nodes_used_ff, nodes_used_in;
   logic [LCNT_W-1:0]    links_used_ff, links_used_in;
   logic [IDX_W-1:0]     idx_ff, idx_in, cmp_idx_ff, cmp_idx_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic                 f_found_ff, f_found_in, t_found_ff, t_found_in;
   logic [NODE_AW-1:0]   f_slot_ff, f_slot_in, t_slot_ff, t_slot_in;
   logic                 l_hit_ff, l_hit_in;
   logic [LINK_AW-1:0]   l_slot_ff, l_slot_in;
   snnu_pkg::status_type status_ff, status_in;
   logic [15:0]          rdval_ff, rdval_in;
   logic [NODE_AW-1:0]   dest_ff, dest_in;
   logic signed [15:0]   weight_ff, weight_in;
   logic signed [31:0]   prod_ff, prod_in;
   logic [9:0]           tidx_ff, tidx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_value_ff, rsp_value_in;
   snnu_pkg::status_type rsp_status_ff, rsp_status_in;

   logic                 id_we, sig_we, sum_we, lnk_we;
   logic [NODE_AW-1:0]   id_wa, sig_wa, sum_wa, sig_ra, sum_ra;
   logic [15:0]          id_wd, sig_wd;
   logic [39:0]          sum_wd;
   logic [LINK_AW-1:0]   lnk_wa, lnk_ra;
   logic [NODE_AW-1:0]   src_wd, dst_wd;
   logic [15:0]          wgt_wd;
   logic [15:0]          id_rd, sig_rd, wgt_rd;
   logic [39:0]          sum_rd;
   logic [NODE_AW-1:0]   src_rd, dst_rd;

   logic                 accept, issue_n, issue_l;
   logic [1:0]           need;
   logic [NCNT_W:0]      nodes_after;
   logic [27:0]          shifted;
   logic [15:0]          clipped;

   snnu_ram #(.WIDTH(16), .DEPTH(NODES)) u_ident (
      .clock(clock), .wr_en(id_we), .wr_addr(id_wa), .wr_data(id_wd),
      .rd_addr(idx_ff[NODE_AW-1:0]), .rd_data(id_rd));
   snnu_ram #(.WIDTH(16), .DEPTH(NODES)) u_signal (
      .clock(clock), .wr_en(sig_we), .wr_addr(sig_wa), .wr_data(sig_wd),
      .rd_addr(sig_ra), .rd_data(sig_rd));
   snnu_ram #(.WIDTH(40), .DEPTH(NODES)) u_sum (
      .clock(clock), .wr_en(sum_we), .wr_addr(sum_wa), .wr_data(sum_wd),
      .rd_addr(sum_ra), .rd_data(sum_rd));
   snnu_ram #(.WIDTH(NODE_AW), .DEPTH(LINKS)) u_lsrc (
      .clock(clock), .wr_en(lnk_we), .wr_addr(lnk_wa), .wr_data(src_wd),
      .rd_addr(lnk_ra), .rd_data(src_rd));
   snnu_ram #(.WIDTH(NODE_AW), .DEPTH(LINKS)) u_ldst (
      .clock(clock), .wr_en(lnk_we), .wr_addr(lnk_wa), .wr_data(dst_wd),
      .rd_addr(lnk_ra), .rd_data(dst_rd));
   snnu_ram #(.WIDTH(16), .DEPTH(LINKS)) u_lwgt (
      .clock(clock), .wr_en(lnk_we), .wr_addr(lnk_wa), .wr_data(wgt_wd),
      .rd_addr(lnk_ra), .rd_data(wgt_rd));

   assign req_tready = (state_ff == snnu_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign issue_n = idx_ff < IDX_W'(nodes_used_ff);
   assign issue_l = idx_ff < IDX_W'(links_used_ff);
   assign need    = {1'b0, !f_found_ff} + {1'b0, (!t_found_ff && (id_a_ff != id_b_ff))};
   assign nodes_after = {1'b0, nodes_used_ff} + (NCNT_W+1)'(need);
   assign shifted = sum_rd[39:12];

   always_comb begin
      if (shifted[27:15] == {13{shifted[15]}}) begin
         clipped = shifted[15:0];
      end else if (shifted[27]) begin
         clipped = 16'h8000;
      end else begin
         clipped = 16'h7fff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_a_in       = id_a_ff;
      id_b_in       = id_b_ff;
      value_in      = value_ff;
      nodes_used_in = nodes_used_ff;
      links_used_in = links_used_ff;
      idx_in        = idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmp_vld_in    = 1'b0;
      f_found_in    = f_found_ff;
      t_found_in    = t_found_ff;
      f_slot_in     = f_slot_ff;
      t_slot_in     = t_slot_ff;
      l_hit_in      = l_hit_ff;
      l_slot_in     = l_slot_ff;
      status_in     = status_ff;
      rdval_in      = rdval_ff;
      dest_in       = dest_ff;
      weight_in     = weight_ff;
      prod_in       = prod_ff;
      tidx_in       = tidx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      id_we  = 1'b0;
      id_wa  = f_slot_ff;
      id_wd  = id_a_ff;
      sig_we = 1'b0;
      sig_wa = f_slot_ff;
      sig_wd = '0;
      sig_ra = f_slot_ff;
      sum_we = 1'b0;
      sum_wa = idx_ff[NODE_AW-1:0];
      sum_wd = '0;
      sum_ra = idx_ff[NODE_AW-1:0];
      lnk_we = 1'b0;
      lnk_wa = links_used_ff[LINK_AW-1:0];
      lnk_ra = idx_ff[LINK_AW-1:0];
      src_wd = f_slot_ff;
      dst_wd = t_slot_ff;
      wgt_wd = value_ff;

      case (state_ff)
         snnu_pkg::S_IDLE: begin
            if (accept) begin
               op_in      = req_tuser;
               id_a_in    = req_tdata[15:0];
               id_b_in    = req_tdata[31:16];
               value_in   = req_tdata[47:32];
               idx_in     = '0;
               f_found_in = 1'b0;
               t_found_in = 1'b0;
               l_hit_in   = 1'b0;
               status_in  = snnu_pkg::STAT_OK;
               rdval_in   = '0;
               state_in   = (req_tuser == snnu_pkg::OP_ACTIVATE) ?
                            snnu_pkg::S_CLR : snnu_pkg::S_NSCAN;
            end
         end
         snnu_pkg::S_NSCAN: begin
            if (cmp_vld_ff) begin
               if (id_rd == id_a_ff) begin
                  f_found_in = 1'b1;
                  f_slot_in  = cmp_idx_ff[NODE_AW-1:0];
               end
               if (id_rd == id_b_ff) begin
                  t_found_in = 1'b1;
                  t_slot_in  = cmp_idx_ff[NODE_AW-1:0];
               end
            end
            if (issue_n) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = idx_ff;
               idx_in     = idx_ff + 1'b1;
            end else if (!cmp_vld_ff) begin
               idx_in = '0;
               if (op_ff == snnu_pkg::OP_LINK && f_found_ff && t_found_ff) begin
                  state_in = snnu_pkg::S_LSCAN;
               end else begin
                  state_in = snnu_pkg::S_DECIDE;
               end
            end
         end
         snnu_pkg::S_LSCAN: begin
            if (cmp_vld_ff && src_rd == f_slot_ff && dst_rd == t_slot_ff) begin
               l_hit_in  = 1'b1;
               l_slot_in = cmp_idx_ff[LINK_AW-1:0];
            end
            if (issue_l) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = idx_ff;
               idx_in     = idx_ff + 1'b1;
            end else if (!cmp_vld_ff) begin
               state_in = snnu_pkg::S_DECIDE;
            end
         end
         snnu_pkg::S_DECIDE: begin
            state_in = snnu_pkg::S_DONE;
            case (op_ff)
               snnu_pkg::OP_SET: begin
                  if (!f_found_ff) begin
                     status_in = snnu_pkg::STAT_UNKNOWN;
                  end else begin
                     sig_we = 1'b1;
                     sig_wd = value_ff;
                  end
               end
               snnu_pkg::OP_READ: begin
                  if (!f_found_ff) begin
                     status_in = snnu_pkg::STAT_UNKNOWN;
                  end else begin
                     state_in = snnu_pkg::S_SRD;
                  end
               end
               snnu_pkg::OP_LINK: begin
                  if (l_hit_ff) begin
                     lnk_we = 1'b1;
                     lnk_wa = l_slot_ff;
                     src_wd = f_slot_ff;
                     dst_wd = t_slot_ff;
                  end else if (nodes_after > NODES_LIM) begin
                     status_in = snnu_pkg::STAT_NODE_FULL;
                  end else if (links_used_ff >= LINKS_LIM) begin
                     status_in = snnu_pkg::STAT_LINK_FULL;
                  end else begin
                     f_slot_in = f_found_ff ? f_slot_ff : nodes_used_ff[NODE_AW-1:0];
                     if (t_found_ff) begin
                        t_slot_in = t_slot_ff;
                     end else if (id_a_ff == id_b_ff) begin
                        t_slot_in = f_found_ff ? f_slot_ff : nodes_used_ff[NODE_AW-1:0];
                     end else begin
                        t_slot_in = nodes_used_ff[NODE_AW-1:0] +
                                    NODE_AW'(!f_found_ff);
                     end
                     state_in = snnu_pkg::S_ADDF;
                  end
               end
               default: begin
                  state_in = snnu_pkg::S_DONE;
               end
            endcase
         end
         snnu_pkg::S_ADDF: begin
            id_we  = !f_found_ff;
            id_wa  = f_slot_ff;
            id_wd  = id_a_ff;
            sig_we = !f_found_ff;
            sig_wa = f_slot_ff;
            state_in = snnu_pkg::S_ADDT;
         end
         snnu_pkg::S_ADDT: begin
            id_we  = !t_found_ff && (id_a_ff != id_b_ff);
            id_wa  = t_slot_ff;
            id_wd  = id_b_ff;
            sig_we = id_we;
            sig_wa = t_slot_ff;
            lnk_we = 1'b1;
            nodes_used_in = nodes_after[NCNT_W-1:0];
            links_used_in = links_used_ff + 1'b1;
            state_in = snnu_pkg::S_DONE;
         end
         snnu_pkg::S_SRD: begin
            rdval_in = sig_rd;
            state_in = snnu_pkg::S_DONE;
         end
         snnu_pkg::S_CLR: begin
            if (issue_n) begin
               sum_we = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else begin
               idx_in   = '0;
               state_in = snnu_pkg::S_LRD;
            end
         end
         snnu_pkg::S_LRD: begin
            if (issue_l) begin
               state_in = snnu_pkg::S_SRC;
            end else begin
               idx_in   = '0;
               state_in = snnu_pkg::S_NRD;
            end
         end
         snnu_pkg::S_SRC: begin
            sig_ra    = src_rd;
            dest_in   = dst_rd;
            weight_in = wgt_rd;
            state_in  = snnu_pkg::S_MUL;
         end
         snnu_pkg::S_MUL: begin
            prod_in  = $signed(sig_rd) * weight_ff;
            sum_ra   = dest_ff;
            state_in = snnu_pkg::S_ACC;
         end
         snnu_pkg::S_ACC: begin
            sum_we   = 1'b1;
            sum_wa   = dest_ff;
            sum_wd   = sum_rd + {{8{prod_ff[31]}}, prod_ff};
            idx_in   = idx_ff + 1'b1;
            state_in = snnu_pkg::S_LRD;
         end
         snnu_pkg::S_NRD: begin
            state_in = issue_n ? snnu_pkg::S_CVT : snnu_pkg::S_DONE;
         end
         snnu_pkg::S_CVT: begin
            tidx_in  = {~clipped[15], clipped[14:6]};
            state_in = snnu_pkg::S_NWR;
         end
         snnu_pkg::S_NWR: begin
            sig_we   = 1'b1;
            sig_wa   = idx_ff[NODE_AW-1:0];
            sig_wd   = snnu_pkg::SIG_TABLE[tidx_ff];
            idx_in   = idx_ff + 1'b1;
            state_in = snnu_pkg::S_NRD;
         end
         snnu_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rdval_ff;
               rsp_status_in = status_ff;
               state_in      = snnu_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = snnu_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= snnu_pkg::S_IDLE;
         nodes_used_ff <= '0;
         links_used_ff <= '0;
         cmp_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nodes_used_ff <= nodes_used_in;
         links_used_ff <= links_used_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_a_ff       <= id_a_in;
      id_b_ff       <= id_b_in;
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      f_found_ff    <= f_found_in;
      t_found_ff    <= t_found_in;
      f_slot_ff     <= f_slot_in;
      t_slot_ff     <= t_slot_in;
      l_hit_ff      <= l_hit_in;
      l_slot_ff     <= l_slot_in;
      status_ff     <= status_in;
      rdval_ff      <= rdval_in;
      dest_ff       <= dest_in;
      weight_ff     <= weight_in;
      prod_ff       <= prod_in;
      tidx_ff       <= tidx_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != snnu_pkg::S_IDLE)
      else $error("sequencer idle after accepted transaction");

   assert property (@(posedge clock) disable iff (reset)
      {1'b0, nodes_used_ff} <= NODES_LIM)
      else $error("node count beyond table size");

   assert property (@(posedge clock) disable iff (reset)
      links_used_ff <= LINKS_LIM)
      else $error("link count beyond table size");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == snnu_pkg::S_DONE))
      else $error("response raised outside completion");

endmodule

`default_nettype wire
